[rtl/sst_pkg.sv]
package sst_pkg;

    localparam int SINE_DEPTH_DEF = 1024;

    localparam logic [7:0] REG_POSITION = 8'h1E;
    localparam logic [7:0] REG_SPEED    = 8'h54;
    localparam logic [7:0] REG_POWER    = 8'h46;
    localparam logic [15:0] POWER_FREE  = 16'h0200;
    localparam logic [10:0] START_ID    = 11'h7FF;
    localparam logic [10:0] CMD_BASE_ID = 11'h100;
    localparam logic [7:0] CHECK_BASE   = 8'h88;
    localparam logic [7:0] FRAME_LEN    = 8'd2;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [35:0] OFFSET_TURN = 36'd44798133900;

    localparam logic [7:0] CFG_SLAVE    = 8'd0;
    localparam logic [7:0] CFG_WAIT     = 8'd1;
    localparam logic [7:0] CFG_SPD_NORM = 8'd2;
    localparam logic [7:0] CFG_SPD_RET  = 8'd3;
    localparam logic [7:0] CFG_HOME     = 8'd4;
    localparam logic [7:0] CFG_AMP_SLEW = 8'd5;
    localparam logic [7:0] CFG_CTR_SLEW = 8'd6;

    typedef enum logic [1:0] {
        SEQ_NORMAL      = 2'd0,
        SEQ_WAIT_FREE   = 2'd1,
        SEQ_WAIT_RETURN = 2'd2,
        SEQ_WAIT_HOME   = 2'd3
    } t_seq;

    typedef struct packed {
        logic accept;
        logic seq;
        logic slew;
        logic addr;
        logic rom;
        logic mul;
        logic pos;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic started;
        logic run;
        logic wave;
        logic any;
        logic last;
    } t_stat;

    typedef logic [31:0] t_step_tab [256];

    // quarter sine in q1.15 from a short odd series, argument in q30
    function automatic logic [15:0] sin_q15(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        term = ((term * x2) >> 30) / 6;   sum = sum - term;
        term = ((term * x2) >> 30) / 20;  sum = sum + term;
        term = ((term * x2) >> 30) / 42;  sum = sum - term;
        term = ((term * x2) >> 30) / 72;  sum = sum + term;
        term = ((term * x2) >> 30) / 110; sum = sum - term;
        term = ((term * x2) >> 30) / 156; sum = sum + term;
        sum = (sum + 64'd16384) >> 15;
        return (sum > 64'd32767) ? 16'd32767 : sum[15:0];
    endfunction

    // phase step per tick for each frequency code
    function automatic t_step_tab build_step();
        t_step_tab t;
        logic [63:0] v;
        for (int f = 0; f < 256; f++) begin
            v = ((64'(f) << 32) + 64'd2500) / 64'd5000;
            t[f] = v[31:0];
        end
        return t;
    endfunction

endpackage

[rtl/sst_ctrl.sv]
module sst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_tick,
    input  logic          i_out_ready,
    input  sst_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output sst_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SEQ  = 8'b0000_0010,
        S_SLEW = 8'b0000_0100,
        S_ADDR = 8'b0000_1000,
        S_ROM  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_POS  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_tick && i_stat.started) n_state = S_SEQ;
                end
            end
            S_SEQ: begin
                o_cmd.seq = 1'b1;
                if (i_stat.run) n_state = S_SLEW;
                else if (i_stat.any) n_state = S_OUT;
                else n_state = S_IDLE;
            end
            S_SLEW: begin
                o_cmd.slew = 1'b1;
                if (i_stat.wave) n_state = S_ADDR;
                else if (i_stat.any) n_state = S_OUT;
                else n_state = S_IDLE;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state = S_ROM;
            end
            S_ROM: begin
                o_cmd.rom = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_stat.last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

[rtl/sst_dp.sv]
module sst_dp #(
    parameter int SINE_TABLE_DEPTH = sst_pkg::SINE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sst_pkg::t_cmd i_cmd,
    output sst_pkg::t_stat o_stat,
    input  logic          i_in_tick,
    input  logic [10:0]   i_frame_id,
    input  logic [7:0]    i_mode_flags,
    input  logic [7:0]    i_frequency_code,
    input  logic [15:0]   i_amplitude_target,
    input  logic [15:0]   i_phase_offset,
    input  logic [15:0]   i_center_target,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_index,
    input  logic [23:0]   i_cfg_data,
    output logic [7:0]    o_node_address,
    output logic [7:0]    o_register_address,
    output logic [15:0]   o_register_value,
    output logic [7:0]    o_check_byte,
    output logic          o_last_of_tick
);

    localparam int D  = SINE_TABLE_DEPTH;
    localparam int IW = $clog2(D + 1);
    localparam int PW = 30 + IW;

    typedef logic [15:0] t_rom [0:D];

    function automatic t_rom build_rom();
        t_rom t;
        logic [63:0] x;
        for (int i = 0; i <= D; i++) begin
            x = (64'(i) * sst_pkg::HALF_PI_Q30 + 64'(D / 2)) / 64'(D);
            t[i] = sst_pkg::sin_q15(x);
        end
        return t;
    endfunction

    localparam t_rom SINE_ROM = build_rom();
    localparam sst_pkg::t_step_tab STEP_TAB = sst_pkg::build_step();

    function automatic logic [23:0] slew(logic [23:0] cur, logic [23:0] tgt,
                                         logic [23:0] step);
        logic [23:0] res;
        res = cur;
        if (cur < tgt) res = ((tgt - cur) <= step) ? tgt : cur + step;
        else if (cur > tgt) res = ((cur - tgt) <= step) ? tgt : cur - step;
        return res;
    endfunction

    // configuration
    logic [7:0]  r_slave, r_wait_ticks;
    logic [15:0] r_spd_norm, r_spd_ret, r_home_pos;
    logic [23:0] r_amp_slew, r_ctr_slew;

    // held command and sequencer state
    logic        r_started, r_motor_free, r_home_done;
    logic [3:0]  r_flags;
    logic [7:0]  r_freq;
    logic [15:0] r_amp_tgt, r_phase_off, r_ctr_tgt;
    sst_pkg::t_seq r_seq;
    logic [7:0]  r_wait_cnt;
    logic [23:0] r_amp, r_ctr;
    logic [31:0] r_phase;

    // result queue
    logic [7:0]  r_q_reg [3];
    logic [15:0] r_q_val [3];
    logic [1:0]  r_cnt, r_rd;

    // wave pipeline
    logic [31:0] r_off;
    logic [IW-1:0] r_idx;
    logic [1:0]  r_quad;
    logic [15:0] r_sin;
    logic signed [41:0] r_prod;

    logic wave, home, freef, ret;
    assign wave  = r_flags[0];
    assign home  = r_flags[1];
    assign freef = r_flags[2];
    assign ret   = r_flags[3];

    // sequencer step, evaluated combinationally in the seq cycle
    sst_pkg::t_seq n_seq;
    logic        n_motor_free, n_home_done, n_clr_wave;
    logic [7:0]  n_wait_cnt;
    logic [1:0]  n_cnt;
    logic [7:0]  n_q_reg [3];
    logic [15:0] n_q_val [3];

    always_comb begin
        n_seq = r_seq;
        n_motor_free = r_motor_free;
        n_home_done = r_home_done;
        n_clr_wave = 1'b0;
        n_wait_cnt = r_wait_cnt;
        n_cnt = 2'd0;
        for (int k = 0; k < 3; k++) begin
            n_q_reg[k] = r_q_reg[k];
            n_q_val[k] = r_q_val[k];
        end
        if (r_seq == sst_pkg::SEQ_NORMAL) begin
            if ((freef && !r_motor_free) || (ret && r_motor_free) ||
                (home && !r_home_done)) begin
                n_q_reg[0] = sst_pkg::REG_SPEED;    n_q_val[0] = r_spd_ret;
                n_q_reg[1] = sst_pkg::REG_POSITION; n_q_val[1] = r_home_pos;
                n_cnt = 2'd2;
                if (freef && !r_motor_free) begin
                    n_seq = sst_pkg::SEQ_WAIT_FREE;
                end else if (ret && r_motor_free) begin
                    n_q_reg[2] = sst_pkg::REG_POWER; n_q_val[2] = 16'd0;
                    n_cnt = 2'd3;
                    n_seq = sst_pkg::SEQ_WAIT_RETURN;
                end else begin
                    n_seq = sst_pkg::SEQ_WAIT_HOME;
                end
                n_wait_cnt = r_wait_ticks;
            end
        end else if (r_wait_cnt > 8'd1) begin
            n_wait_cnt = r_wait_cnt - 8'd1;
        end else begin
            n_wait_cnt = 8'd0;
            n_q_reg[0] = sst_pkg::REG_SPEED; n_q_val[0] = r_spd_norm;
            n_cnt = 2'd1;
            unique case (r_seq)
                sst_pkg::SEQ_WAIT_FREE: begin
                    n_q_reg[1] = sst_pkg::REG_POWER; n_q_val[1] = sst_pkg::POWER_FREE;
                    n_cnt = 2'd2;
                    n_motor_free = 1'b1;
                    n_home_done = 1'b1;
                    n_clr_wave = 1'b1;
                end
                sst_pkg::SEQ_WAIT_RETURN: n_motor_free = 1'b0;
                default: begin
                    n_home_done = 1'b1;
                    n_clr_wave = 1'b1;
                end
            endcase
            n_seq = sst_pkg::SEQ_NORMAL;
        end
    end

    // phase index of the sine lookup
    logic [31:0]   w_ph;
    logic [PW-1:0] w_iprod;
    logic [IW-1:0] w_idx;
    assign w_ph = r_phase + r_off;
    assign w_iprod = PW'(w_ph[29:0]) * PW'(D);
    assign w_idx = (w_iprod[PW-1:30] > IW'(D)) ? IW'(D) : w_iprod[PW-1:30];

    logic [51:0] w_offp;
    assign w_offp = 52'(r_phase_off) * 52'(sst_pkg::OFFSET_TURN) + 52'd32768;

    logic signed [16:0] w_sine;
    assign w_sine = (home || freef) ? 17'sd0 :
                    (r_quad[1] ? -$signed({1'b0, r_sin}) : $signed({1'b0, r_sin}));

    logic signed [42:0] w_pos;
    logic [15:0] w_val;
    assign w_pos = $signed({4'b0, r_ctr, 15'b0}) + 43'(r_prod);
    always_comb begin
        if (w_pos[42]) w_val = 16'd0;
        else if (|w_pos[41:39]) w_val = 16'hFFFF;
        else w_val = w_pos[38:23];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave <= 8'd3;
            r_wait_ticks <= 8'd150;
            r_spd_norm <= 16'd1000;
            r_spd_ret <= 16'd200;
            r_home_pos <= 16'd8192;
            r_amp_slew <= 24'd5825;
            r_ctr_slew <= 24'd11651;
            r_started <= 1'b0;
            r_motor_free <= 1'b0;
            r_home_done <= 1'b0;
            r_flags <= 4'd1;
            r_freq <= 8'd50;
            r_amp_tgt <= 16'd0;
            r_phase_off <= 16'd0;
            r_ctr_tgt <= 16'd8192;
            r_seq <= sst_pkg::SEQ_NORMAL;
            r_wait_cnt <= 8'd0;
            r_amp <= 24'd0;
            r_ctr <= 24'(8192 * 256);
            r_phase <= 32'd0;
            r_cnt <= 2'd0;
            r_rd <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sst_pkg::CFG_SLAVE:    r_slave <= i_cfg_data[7:0];
                    sst_pkg::CFG_WAIT:     r_wait_ticks <= i_cfg_data[7:0];
                    sst_pkg::CFG_SPD_NORM: r_spd_norm <= i_cfg_data[15:0];
                    sst_pkg::CFG_SPD_RET:  r_spd_ret <= i_cfg_data[15:0];
                    sst_pkg::CFG_HOME:     r_home_pos <= i_cfg_data[15:0];
                    sst_pkg::CFG_AMP_SLEW: r_amp_slew <= i_cfg_data;
                    sst_pkg::CFG_CTR_SLEW: r_ctr_slew <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_cnt <= 2'd0;
                r_rd <= 2'd0;
                if (!i_in_tick) begin
                    if (i_frame_id == sst_pkg::START_ID) begin
                        r_started <= 1'b1;
                    end else if (i_frame_id == sst_pkg::CMD_BASE_ID + 11'(r_slave)) begin
                        r_flags <= i_mode_flags[3:0];
                        r_freq <= i_frequency_code;
                        r_amp_tgt <= i_amplitude_target;
                        r_phase_off <= i_phase_offset;
                        r_ctr_tgt <= i_center_target;
                    end
                end
            end
            if (i_cmd.seq) begin
                r_seq <= n_seq;
                r_motor_free <= n_motor_free;
                r_home_done <= n_home_done;
                r_wait_cnt <= n_wait_cnt;
                r_cnt <= n_cnt;
                if (n_clr_wave) begin
                    r_amp <= 24'd0;
                    r_phase <= 32'd0;
                end
            end
            if (i_cmd.slew) begin
                if (!home) r_home_done <= 1'b0;
                r_amp <= slew(r_amp, {r_amp_tgt, 8'd0}, r_amp_slew);
                r_ctr <= slew(r_ctr, {r_ctr_tgt, 8'd0}, r_ctr_slew);
            end
            if (i_cmd.pos) begin
                r_cnt <= r_cnt + 2'd1;
                r_phase <= r_phase + STEP_TAB[r_freq];
            end
            if (i_cmd.pop) r_rd <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seq) begin
            for (int k = 0; k < 3; k++) begin
                r_q_reg[k] <= n_q_reg[k];
                r_q_val[k] <= n_q_val[k];
            end
        end
        if (i_cmd.pos) begin
            r_q_reg[r_cnt] <= sst_pkg::REG_POSITION;
            r_q_val[r_cnt] <= w_val;
        end
        if (i_cmd.slew) r_off <= w_offp[47:16];
        if (i_cmd.addr) begin
            r_idx <= w_idx;
            r_quad <= w_ph[31:30];
        end
        if (i_cmd.rom) r_sin <= r_quad[0] ? SINE_ROM[IW'(D) - r_idx] : SINE_ROM[r_idx];
        if (i_cmd.mul) r_prod <= $signed({1'b0, r_amp}) * w_sine;
    end

    assign o_stat.started = r_started;
    assign o_stat.run     = (n_seq == sst_pkg::SEQ_NORMAL) && !n_motor_free;
    assign o_stat.wave    = wave;
    assign o_stat.any     = i_cmd.seq ? (n_cnt != 2'd0) : (r_cnt != 2'd0);
    assign o_stat.last    = (r_rd == r_cnt - 2'd1);

    assign o_node_address     = r_slave;
    assign o_register_address = r_q_reg[r_rd];
    assign o_register_value   = r_q_val[r_rd];
    assign o_check_byte       = sst_pkg::CHECK_BASE - (r_slave + r_q_reg[r_rd] +
                                sst_pkg::FRAME_LEN + r_q_val[r_rd][7:0] +
                                r_q_val[r_rd][15:8]);
    assign o_last_of_tick     = o_stat.last;

endmodule

[rtl/servo_sine_trajectory_sequencer_unit.sv]
// channel   dir  handshake                 payload
// s_axis    in   i_s_tvalid / o_s_tready   tdata 80 bits, tuser req_type
// m_axis    out  o_m_tvalid / i_m_tready   tdata 40 bits, tlast last_of_tick
// cfg       in   i_cfg_valid / o_cfg_ready index 8 bits, data 24 bits
//
// a frame beat, or a tick beat before the start frame, is only accepted; a tick beat
// then takes the sequencer step, while running slewing with the phase offset and, in
// wave mode, the sine path (index, table read, multiply, position), then sends its
// servo frames, one per cycle while the output is not stalled
// one input beat at a time; the next is taken after the last output beat
// synchronous active-low reset; the sine table is a constant rom, no fill pass
// output stalls hold the frame in place
module servo_sine_trajectory_sequencer_unit #(
    parameter int SINE_TABLE_DEPTH = sst_pkg::SINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // frame_id, mode_flags, frequency_code, amplitude_target, phase_offset,
    // center_target, zero pad
    input  logic [79:0] i_s_tdata,
    // req_type
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // node_address, register_address, register_value, check_byte
    output logic [39:0] o_m_tdata,
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    sst_pkg::t_cmd  w_cmd;
    sst_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    sst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_tick   (i_s_tuser),
        .i_out_ready (i_m_tready),
        .i_stat      (w_stat),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (w_cmd)
    );

    sst_dp #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_in_tick          (i_s_tuser),
        .i_frame_id         (i_s_tdata[10:0]),
        .i_mode_flags       (i_s_tdata[18:11]),
        .i_frequency_code   (i_s_tdata[26:19]),
        .i_amplitude_target (i_s_tdata[42:27]),
        .i_phase_offset     (i_s_tdata[58:43]),
        .i_center_target    (i_s_tdata[74:59]),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_node_address     (o_m_tdata[7:0]),
        .o_register_address (o_m_tdata[15:8]),
        .o_register_value   (o_m_tdata[31:16]),
        .o_check_byte       (o_m_tdata[39:32]),
        .o_last_of_tick     (o_m_tlast)
    );

endmodule

[rtl/sst_checker.sv]
module sst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tlast
);

    logic [7:0] w_sum;
    assign w_sum = o_m_tdata[7:0] + o_m_tdata[15:8] + 8'd2 + o_m_tdata[23:16] +
                   o_m_tdata[31:24] + o_m_tdata[39:32];

    // no input beat is taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while output valid");

    a_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_sum == 8'h88))
        else $error("bad check byte");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (!o_m_tvalid && o_s_tready))
        else $error("output continues after last beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled beat changed");

endmodule

bind servo_sine_trajectory_sequencer_unit sst_checker u_sst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

[sim/testbench.sv]
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CFG_NONE = 8'd7;

    typedef enum logic [1:0] {ROW_FRAME, ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [10:0] id;
        logic [7:0]  flags;
        logic [7:0]  freq;
        logic [15:0] amp;
        logic [15:0] phase;
        logic [15:0] center;
        logic [23:0] cfg_data;
        bit          typed;
        int          n_typed;
        logic [7:0]  e_reg;
        logic [15:0] e_val;
    } t_row;

    typedef struct {
        logic [7:0]  node;
        logic [7:0]  regaddr;
        logic [15:0] value;
        logic [7:0]  check;
        logic        last;
    } t_servo_frame;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    servo_sine_trajectory_sequencer_unit DUT (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("== FAIL ==");
        $finish;
    end

    // predictor state
    logic [7:0]  m_slave, m_wait_ticks;
    logic [15:0] m_spd_norm, m_spd_ret, m_home_pos;
    logic [23:0] m_amp_slew, m_ctr_slew;
    bit          m_started, m_motor_free, m_home_done;
    logic [3:0]  m_flags;
    logic [7:0]  m_freq, m_wait_cnt;
    logic [15:0] m_amp_tgt, m_phase_ofs, m_ctr_tgt;
    sst_pkg::t_seq m_seq;
    logic [23:0] m_amp, m_ctr;
    logic [31:0] m_phase;
    logic [15:0] quarter_wave [0:sst_pkg::SINE_DEPTH_DEF];

    t_servo_frame frames_due[$];
    int  mismatches = 0;
    bit  calm = 0;

    function automatic logic [15:0] series_sine(logic [63:0] x);
        logic [63:0] x2, term, acc;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        acc = (acc + 64'd16384) >> 15;
        return (acc > 64'd32767) ? 16'd32767 : acc[15:0];
    endfunction

    function automatic logic [7:0] frame_check(logic [7:0] node, logic [7:0] ra,
                                               logic [15:0] v);
        return sst_pkg::CHECK_BASE - (node + ra + sst_pkg::FRAME_LEN + v[7:0] + v[15:8]);
    endfunction

    function automatic logic [23:0] slew_to(logic [23:0] cur, logic [23:0] tgt,
                                            logic [23:0] stp);
        if (cur < tgt) return (tgt - cur <= stp) ? tgt : cur + stp;
        if (cur > tgt) return (cur - tgt <= stp) ? tgt : cur - stp;
        return cur;
    endfunction

    function automatic int signed wave_sample(logic [31:0] ph);
        logic [9:0] idx;
        int signed v;
        idx = ph[29:20];
        v = ph[30] ? int'(quarter_wave[sst_pkg::SINE_DEPTH_DEF - idx])
                   : int'(quarter_wave[idx]);
        return ph[31] ? -v : v;
    endfunction

    function automatic void reset_model();
        m_slave = 8'd3; m_wait_ticks = 8'd150; m_spd_norm = 16'd1000;
        m_spd_ret = 16'd200; m_home_pos = 16'd8192;
        m_amp_slew = 24'd5825; m_ctr_slew = 24'd11651;
        m_started = 0; m_motor_free = 0; m_home_done = 0;
        m_flags = 4'd1; m_freq = 8'd50; m_amp_tgt = '0; m_phase_ofs = '0;
        m_ctr_tgt = 16'd8192; m_seq = sst_pkg::SEQ_NORMAL; m_wait_cnt = '0;
        m_amp = '0; m_ctr = 24'(8192 * 256); m_phase = '0;
        for (int i = 0; i <= sst_pkg::SINE_DEPTH_DEF; i++)
            quarter_wave[i] = series_sine((64'(i) * sst_pkg::HALF_PI_Q30 + 64'd512)
                                          / 64'd1024);
    endfunction

    function automatic void model_reg_write(logic [7:0] idx, logic [23:0] d);
        case (idx)
            sst_pkg::CFG_SLAVE:    m_slave = d[7:0];
            sst_pkg::CFG_WAIT:     m_wait_ticks = d[7:0];
            sst_pkg::CFG_SPD_NORM: m_spd_norm = d[15:0];
            sst_pkg::CFG_SPD_RET:  m_spd_ret = d[15:0];
            sst_pkg::CFG_HOME:     m_home_pos = d[15:0];
            sst_pkg::CFG_AMP_SLEW: m_amp_slew = d;
            sst_pkg::CFG_CTR_SLEW: m_ctr_slew = d;
            default: ;
        endcase
    endfunction

    function automatic void queue_frame(logic [7:0] ra, logic [15:0] v, ref int n);
        t_servo_frame f;
        f.node = m_slave;
        f.regaddr = ra;
        f.value = v;
        f.check = frame_check(m_slave, ra, v);
        f.last = 1'b0;
        frames_due.push_back(f);
        n++;
    endfunction

    // sequencer and wave step for one accepted beat
    function automatic void servo_step(logic tick, logic [79:0] d);
        int n;
        bit wave, home, freef, ret;
        logic [63:0] ofs;
        logic signed [63:0] pos;
        int signed s;
        logic [15:0] val;
        n = 0;
        if (!tick) begin
            if (d[10:0] == sst_pkg::START_ID) m_started = 1;
            else if (d[10:0] == sst_pkg::CMD_BASE_ID + 11'(m_slave)) begin
                m_flags = d[14:11]; m_freq = d[26:19]; m_amp_tgt = d[42:27];
                m_phase_ofs = d[58:43]; m_ctr_tgt = d[74:59];
            end
            return;
        end
        if (!m_started) return;
        wave = m_flags[0]; home = m_flags[1]; freef = m_flags[2]; ret = m_flags[3];
        if (m_seq == sst_pkg::SEQ_NORMAL) begin
            if ((freef && !m_motor_free) || (ret && m_motor_free) ||
                (home && !m_home_done)) begin
                queue_frame(sst_pkg::REG_SPEED, m_spd_ret, n);
                queue_frame(sst_pkg::REG_POSITION, m_home_pos, n);
                if (freef && !m_motor_free) m_seq = sst_pkg::SEQ_WAIT_FREE;
                else if (ret && m_motor_free) begin
                    queue_frame(sst_pkg::REG_POWER, 16'd0, n);
                    m_seq = sst_pkg::SEQ_WAIT_RETURN;
                end else m_seq = sst_pkg::SEQ_WAIT_HOME;
                m_wait_cnt = m_wait_ticks;
            end
        end else if (m_wait_cnt > 1) begin
            m_wait_cnt--;
        end else begin
            m_wait_cnt = '0;
            queue_frame(sst_pkg::REG_SPEED, m_spd_norm, n);
            if (m_seq == sst_pkg::SEQ_WAIT_FREE) begin
                queue_frame(sst_pkg::REG_POWER, sst_pkg::POWER_FREE, n);
                m_motor_free = 1; m_phase = '0; m_amp = '0; m_home_done = 1;
            end else if (m_seq == sst_pkg::SEQ_WAIT_RETURN) begin
                m_motor_free = 0;
            end else begin
                m_amp = '0; m_phase = '0; m_home_done = 1;
            end
            m_seq = sst_pkg::SEQ_NORMAL;
        end
        if (m_seq == sst_pkg::SEQ_NORMAL && !m_motor_free) begin
            if (!home) m_home_done = 0;
            m_amp = slew_to(m_amp, {m_amp_tgt, 8'd0}, m_amp_slew);
            m_ctr = slew_to(m_ctr, {m_ctr_tgt, 8'd0}, m_ctr_slew);
            if (wave) begin
                s = 0;
                if (!home && !freef) begin
                    ofs = (64'(m_phase_ofs) * 64'(sst_pkg::OFFSET_TURN) + 64'h8000) >> 16;
                    s = wave_sample(m_phase + ofs[31:0]);
                end
                pos = (64'(m_ctr) <<< 15) + 64'(m_amp) * 64'(signed'(s));
                if (pos < 0) val = '0;
                else if ((pos >>> 23) > 65535) val = 16'hFFFF;
                else val = 16'(pos >>> 23);
                queue_frame(sst_pkg::REG_POSITION, val, n);
                ofs = ((64'(m_freq) << 32) + 64'd2500) / 64'd5000;
                m_phase = m_phase + ofs[31:0];
            end
        end
        if (n > 0) frames_due[$].last = 1'b1;
    endfunction

    function automatic logic [79:0] pack_cmd(logic [10:0] id, logic [7:0] flags,
            logic [7:0] freq, logic [15:0] amp, logic [15:0] ph, logic [15:0] ctr);
        return {5'd0, ctr, ph, amp, freq, flags, id};
    endfunction

    task automatic send_beat(logic tick, logic [79:0] d, bit typed = 0, int n_typed = 0,
                             logic [7:0] e_reg = '0, logic [15:0] e_val = '0);
        int held;
        t_servo_frame f;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= tick;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        held = frames_due.size();
        servo_step(tick, d);
        if (typed) begin
            while (frames_due.size() > held) void'(frames_due.pop_back());
            if (n_typed > 0) begin
                f.node = m_slave; f.regaddr = e_reg; f.value = e_val;
                f.check = frame_check(m_slave, e_reg, e_val); f.last = 1'b1;
                frames_due.push_back(f);
            end
        end
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // wait until the block is idle before touching registers
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [23:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_reg_write(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    // output side: bursty backpressure
    int stall = 0;
    always @(posedge i_clk) begin
        if (stall > 0) begin
            stall <= stall - 1;
            i_m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall <= $urandom_range(0, 10);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_servo_frame e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected servo frame tdata=%h tlast=%b", o_m_tdata, o_m_tlast);
            end else begin
                e = frames_due.pop_front();
                if (o_m_tdata[7:0] != e.node || o_m_tdata[15:8] != e.regaddr ||
                    o_m_tdata[31:16] != e.value || o_m_tdata[39:32] != e.check ||
                    o_m_tlast != e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("frame mismatch exp node=%h reg=%h val=%h chk=%h last=%b",
                               e.node, e.regaddr, e.value, e.check, e.last);
                        $display(", got node=%h reg=%h val=%h chk=%h last=%b",
                                 o_m_tdata[7:0], o_m_tdata[15:8], o_m_tdata[31:16],
                                 o_m_tdata[39:32], o_m_tlast);
                    end
                end
            end
        end
    end

    t_row rows[$];

    function automatic void add_row(t_row_kind k, logic [10:0] id = '0, logic [7:0] fl = '0,
            logic [7:0] fq = '0, logic [15:0] am = '0, logic [15:0] ph = '0,
            logic [15:0] ct = '0, logic [23:0] cd = '0, bit ty = 0, int nt = 0,
            logic [7:0] er = '0, logic [15:0] ev = '0);
        t_row r;
        r.kind = k; r.id = id; r.flags = fl; r.freq = fq; r.amp = am; r.phase = ph;
        r.center = ct; r.cfg_data = cd; r.typed = ty; r.n_typed = nt;
        r.e_reg = er; r.e_val = ev;
        rows.push_back(r);
    endfunction

    task automatic random_beat();
        int pick;
        logic [7:0] fl;
        logic [15:0] am, ct;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            send_beat(1'b1, 80'({$urandom, $urandom, $urandom}));
        end else if (pick < 88) begin
            fl = ($urandom_range(0, 2) == 0) ? 8'($urandom) : {4'($urandom), 4'd1};
            am = ($urandom_range(0, 4) == 0) ? {16{1'($urandom)}} : 16'($urandom);
            ct = ($urandom_range(0, 4) == 0) ? {16{1'($urandom)}} : 16'($urandom);
            send_beat(1'b0, pack_cmd(sst_pkg::CMD_BASE_ID + 11'(m_slave), fl,
                                     8'($urandom), am, 16'($urandom), ct));
        end else if (pick < 92) begin
            send_beat(1'b0, pack_cmd(sst_pkg::START_ID, 8'($urandom), 8'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom)));
        end else begin
            send_beat(1'b0, 80'({$urandom, $urandom, $urandom}));
        end
    endtask

    initial begin
        reset_model();
        add_row(ROW_TICK, , , , , , , , 1, 0);
        add_row(ROW_FRAME, 11'h103, 8'h01, 8'd0, 16'd0, 16'd0, 16'd8192);
        add_row(ROW_FRAME, 11'h000);
        add_row(ROW_FRAME, sst_pkg::START_ID);
        add_row(ROW_TICK, , , , , , , , 1, 1, sst_pkg::REG_POSITION, 16'd8192);
        add_row(ROW_FRAME, 11'h103, 8'h01, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_row(ROW_TICK);
        add_row(ROW_TICK);
        add_row(ROW_CFG, sst_pkg::CFG_WAIT, , , , , , 24'd0);
        add_row(ROW_FRAME, 11'h103, 8'h04, 8'd10, 16'd500, 16'd0, 16'd0);
        add_row(ROW_TICK);
        add_row(ROW_TICK);
        add_row(ROW_TICK);
        add_row(ROW_FRAME, 11'h103, 8'h08, 8'd10, 16'd500, 16'd0, 16'd0);
        add_row(ROW_TICK);
        add_row(ROW_TICK);
        add_row(ROW_TICK);
        add_row(ROW_FRAME, 11'h103, 8'hF3, 8'd99, 16'd3000, 16'd1000, 16'd0);
        add_row(ROW_TICK);
        add_row(ROW_TICK);
        add_row(ROW_TICK);
        add_row(ROW_CFG, CFG_NONE, , , , , , 24'hFFFFFF);
        add_row(ROW_FRAME, 11'h103, 8'h01, 8'd200, 16'd40000, 16'd1571, 16'd30000);
        add_row(ROW_TICK);
        add_row(ROW_TICK);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_CFG: begin
                    drain();
                    write_reg(rows[i].id[7:0], rows[i].cfg_data);
                end
                ROW_TICK: send_beat(1'b1, 80'({$urandom, $urandom, $urandom}),
                                    rows[i].typed, rows[i].n_typed, rows[i].e_reg,
                                    rows[i].e_val);
                default: send_beat(1'b0, pack_cmd(rows[i].id, rows[i].flags, rows[i].freq,
                                   rows[i].amp, rows[i].phase, rows[i].center));
            endcase
        end

        // longest wait: free transition over 255 ticks
        drain();
        write_reg(sst_pkg::CFG_WAIT, 24'd255);
        send_beat(1'b0, pack_cmd(sst_pkg::CMD_BASE_ID + 11'(m_slave), 8'h04, 8'd1, 16'd1,
                                 16'd1, 16'd1));
        repeat (258) send_beat(1'b1, '0);

        for (int p = 0; p < 6; p++) begin
            drain();
            write_reg(sst_pkg::CFG_SLAVE, p == 0 ? 24'd255 :
                      (p == 1 ? 24'd0 : 24'($urandom_range(0, 255))));
            write_reg(sst_pkg::CFG_WAIT, 24'($urandom_range(0, 4)));
            write_reg(sst_pkg::CFG_SPD_NORM, p == 0 ? 24'hFFFF :
                      (p == 1 ? 24'd0 : 24'($urandom_range(0, 65535))));
            write_reg(sst_pkg::CFG_SPD_RET, p == 1 ? 24'hFFFF :
                      (p == 0 ? 24'd0 : 24'($urandom_range(0, 65535))));
            write_reg(sst_pkg::CFG_HOME, p == 2 ? 24'hFFFF :
                      (p == 3 ? 24'd0 : 24'($urandom_range(0, 65535))));
            write_reg(sst_pkg::CFG_AMP_SLEW, p == 2 ? 24'hFFFFFF :
                      (p == 3 ? 24'd0 : 24'($urandom_range(0, 40000))));
            write_reg(sst_pkg::CFG_CTR_SLEW, p == 3 ? 24'hFFFFFF :
                      (p == 2 ? 24'd0 : 24'($urandom_range(0, 40000))));
            if (p == 5) calm = 1;
            repeat (23) random_beat();
        end

        i_s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
